// File: rtl/tah_pkg.sv
// tah_pkg: shared types and constants for the time-at-level histogram.
// Holds the port payload structs, command and register codes, and the
// front-to-back operation record. No dependencies.
`timescale 1ns / 1ps

package tah_pkg;

  localparam int TIME_W    = 48;
  localparam int RAW_W     = 16;
  localparam int GAIN_W    = 24;
  localparam int SEC_W     = 32;
  localparam int ADDR_W    = 8;
  localparam int CMD_W     = 2;
  localparam int IDX_IN_W  = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd2;

  localparam logic [TIME_W-1:0] WINDOW_END_RESET = 48'hFFFF_FFFF_FFFF;
  localparam logic [GAIN_W-1:0] GAIN_RESET       = 24'h01_0000;

  // spans of 1000 * 2^32 ms or more saturate the seconds count
  localparam logic [TIME_W-1:0] SAT_MS = 48'd4294967296000;
  // ceil(2^52 / 1000): exact ms to s quotient for spans below 2^42
  localparam logic [42:0] SEC_RECIP = 43'd4503599627371;
  localparam int SEC_SHIFT = 52;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_READ,
    OP_READ_OOB,
    OP_CLEAR
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [ADDR_W-1:0] addr;
    logic [SEC_W-1:0]  secs;
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [TIME_W-1:0]       sample_time;
    logic signed [RAW_W-1:0] sample_raw;
    logic [IDX_IN_W-1:0]     bin_index;
  } in_item_t;

  typedef struct packed {
    logic [SEC_W-1:0] bin_seconds;
    logic [SEC_W-1:0] longest_seconds;
  } out_item_t;

endpackage

// File: rtl/time_at_level_histogram.sv
// time_at_level_histogram: top level with configuration registers.
// Instantiates tah_front, tah_queue and tah_back; depends on tah_pkg.
//
// Accepts one transaction per clock while the result side keeps up. A sample
// or end-of-list closes a run through a three-stage front pipeline (window
// clip; duration and level product; bin check and split ms-to-seconds partial
// products), passes a short queue and updates a 32-bit bin in the bin RAM in
// the cycle after its registered read. A read-bin result passes the front
// stages, the queue and the back-end operation and result registers on its way
// out. The bin store has one valid flag per bin, so a clear resets all flags
// together and no clearing pass follows reset. in_stall rises only when a read
// result is held by out_stall and the queue has filled behind it.
`timescale 1ns / 1ps

module time_at_level_histogram
  import tah_pkg::*;
#(
  parameter int MAX_LEVEL   = 30,
  parameter int BIN_COUNT   = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  logic [TIME_W-1:0] window_start_r;
  logic [TIME_W-1:0] window_end_r;
  logic [GAIN_W-1:0] gain_q16_r;

  logic op_valid, q_full, q_empty, q_pop;
  op_t  op_data, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_start_r <= '0;
      window_end_r   <= WINDOW_END_RESET;
      gain_q16_r     <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_START: window_start_r <= cfg_data;
        REG_WINDOW_END:   window_end_r   <= cfg_data;
        REG_GAIN:         gain_q16_r     <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tah_front #(
    .MAX_LEVEL (MAX_LEVEL),
    .BIN_COUNT (BIN_COUNT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .window_start (window_start_r),
    .window_end   (window_end_r),
    .gain_q16     (gain_q16_r),
    .op_valid     (op_valid),
    .op_data      (op_data),
    .op_full      (q_full)
  );

  tah_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (op_valid),
    .push_data  (op_data),
    .full       (q_full),
    .pop_req    (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  tah_back #(
    .BIN_COUNT (BIN_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/tah_ram.sv
// tah_ram: generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`timescale 1ns / 1ps

module tah_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/tah_front.sv
// tah_front: accepts input transactions, tracks the open run and turns
// level changes into bin operations (clip, ms to s, level to bin).
// Depends on tah_pkg.
`timescale 1ns / 1ps

module tah_front
  import tah_pkg::*;
#(
  parameter int MAX_LEVEL = 30,
  parameter int BIN_COUNT = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  input  logic [TIME_W-1:0] window_start,
  input  logic [TIME_W-1:0] window_end,
  input  logic [GAIN_W-1:0] gain_q16,
  output logic              op_valid,
  output op_t               op_data,
  input  logic              op_full
);

  logic front_adv;
  logic accept;

  // run state
  logic [TIME_W-1:0]       run_start_r, run_start_nxt;
  logic signed [RAW_W-1:0] run_raw_r, run_raw_nxt;
  logic                    have_r, have_nxt;
  logic                    past_r, past_nxt;

  // stage 1: clipped span
  logic                    s1_valid_r, s1_valid_nxt;
  op_kind_t                s1_kind_r, s1_kind_nxt;
  logic [ADDR_W-1:0]       s1_addr_r;
  logic [TIME_W-1:0]       s1_lo_r, s1_hi_r;
  logic signed [RAW_W-1:0] s1_raw_r;
  logic [TIME_W-1:0]       lo, hi;

  // stage 2: duration and level product
  logic                    s2_valid_r, s2_valid_nxt;
  op_kind_t                s2_kind_r;
  logic [ADDR_W-1:0]       s2_addr_r;
  logic [TIME_W-1:0]       s2_diff_r;
  logic signed [39:0]      s2_prod_r, prod_nxt;
  logic [TIME_W:0]         diff_wide;

  // stage 3: partial products of the seconds quotient
  logic                    s3_valid_r, s3_valid_nxt;
  op_kind_t                s3_kind_r;
  logic [ADDR_W-1:0]       s3_addr_r, s3_addr_nxt;
  logic                    s3_sat_r;
  logic [42:0]             pp_hh_r, pp_lh_r;
  logic [41:0]             pp_hl_r, pp_ll_r;
  logic [20:0]             x_hi, x_lo;
  logic [23:0]             bin;
  logic                    bin_ok;

  logic [43:0]             pp_mid;
  logic [84:0]             quot_sum;
  logic [SEC_W-1:0]        secs;

  assign front_adv = !s3_valid_r || !op_full;
  assign in_stall  = !front_adv;
  assign accept    = in_valid && front_adv;

  assign lo = (run_start_r > window_start) ? run_start_r : window_start;
  assign hi = (in_data.sample_time < window_end) ? in_data.sample_time : window_end;

  always_comb begin
    run_start_nxt = run_start_r;
    run_raw_nxt   = run_raw_r;
    have_nxt      = have_r;
    past_nxt      = past_r;
    s1_valid_nxt  = 1'b0;
    s1_kind_nxt   = OP_ADD;
    if (accept) begin
      unique case (in_data.command)
        CMD_SAMPLE: begin
          if (!past_r) begin
            if (in_data.sample_time < window_start) begin
              run_start_nxt = in_data.sample_time;
              run_raw_nxt   = in_data.sample_raw;
              have_nxt      = 1'b1;
            end else begin
              if (have_r && run_raw_r != in_data.sample_raw) begin
                s1_valid_nxt = 1'b1;
              end
              if (!have_r || run_raw_r != in_data.sample_raw) begin
                run_start_nxt = in_data.sample_time;
              end
              run_raw_nxt = in_data.sample_raw;
              have_nxt    = 1'b1;
              if (in_data.sample_time > window_end) begin
                past_nxt = 1'b1;
              end
            end
          end
        end
        CMD_END: begin
          if (have_r && run_start_r < window_end) begin
            s1_valid_nxt = 1'b1;
          end
          run_start_nxt = '0;
          run_raw_nxt   = '0;
          have_nxt      = 1'b0;
          past_nxt      = 1'b0;
        end
        CMD_READ: begin
          s1_valid_nxt = 1'b1;
          s1_kind_nxt  = (in_data.bin_index < BIN_COUNT) ? OP_READ : OP_READ_OOB;
        end
        CMD_CLEAR: begin
          s1_valid_nxt = 1'b1;
          s1_kind_nxt  = OP_CLEAR;
        end
      endcase
    end
  end

  assign diff_wide    = {1'b0, s1_hi_r} - {1'b0, s1_lo_r};
  assign s2_valid_nxt = s1_valid_r && !(s1_kind_r == OP_ADD && diff_wide[TIME_W]);
  assign prod_nxt     = $signed(s1_raw_r) * $signed({1'b0, gain_q16});

  assign x_hi   = s2_diff_r[41:21];
  assign x_lo   = s2_diff_r[20:0];
  assign bin    = s2_prod_r[39:16];
  assign bin_ok = !s2_prod_r[39] && (bin <= MAX_LEVEL) && (bin < BIN_COUNT);
  assign s3_valid_nxt = s2_valid_r && !(s2_kind_r == OP_ADD && !bin_ok);
  assign s3_addr_nxt  = (s2_kind_r == OP_ADD) ? bin[ADDR_W-1:0] : s2_addr_r;

  assign pp_mid   = {2'b0, pp_hl_r} + {1'b0, pp_lh_r};
  assign quot_sum = {pp_hh_r, 42'd0} + {20'd0, pp_mid, 21'd0} + {43'd0, pp_ll_r};
  assign secs     = s3_sat_r ? '1 : quot_sum[SEC_SHIFT +: SEC_W];

  assign op_valid     = s3_valid_r;
  assign op_data.kind = s3_kind_r;
  assign op_data.addr = s3_addr_r;
  assign op_data.secs = secs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_start_r <= '0;
      run_raw_r   <= '0;
      have_r      <= 1'b0;
      past_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
    end else begin
      run_start_r <= run_start_nxt;
      run_raw_r   <= run_raw_nxt;
      have_r      <= have_nxt;
      past_r      <= past_nxt;
      if (front_adv) begin
        s1_valid_r <= s1_valid_nxt;
        s2_valid_r <= s2_valid_nxt;
        s3_valid_r <= s3_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (front_adv) begin
      s1_kind_r <= s1_kind_nxt;
      s1_addr_r <= {{(ADDR_W - IDX_IN_W){1'b0}}, in_data.bin_index};
      s1_lo_r   <= lo;
      s1_hi_r   <= hi;
      s1_raw_r  <= run_raw_r;
      s2_kind_r <= s1_kind_r;
      s2_addr_r <= s1_addr_r;
      s2_diff_r <= diff_wide[TIME_W-1:0];
      s2_prod_r <= prod_nxt;
      s3_kind_r <= s2_kind_r;
      s3_addr_r <= s3_addr_nxt;
      s3_sat_r  <= s2_diff_r >= SAT_MS;
      pp_hh_r   <= x_hi * SEC_RECIP[42:21];
      pp_hl_r   <= x_hi * SEC_RECIP[20:0];
      pp_lh_r   <= x_lo * SEC_RECIP[42:21];
      pp_ll_r   <= x_lo * SEC_RECIP[20:0];
    end
  end

`ifndef SYNTHESIS
  a_past_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    past_r |-> have_r)
    else $error("window passed with no open run");

  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.command == CMD_END) |=> (!have_r && !past_r))
    else $error("end of list left the run open");
`endif

endmodule

// File: rtl/tah_queue.sv
// tah_queue: short register FIFO of bin operations between front and back.
// Depends on tah_pkg.
`timescale 1ns / 1ps

module tah_queue
  import tah_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  op_t  push_data,
  output logic full,
  input  logic pop_req,
  output logic empty,
  output op_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = count_r == CNT_W'(DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push_valid && !full;
  assign do_pop  = pop_req && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a transaction");
`endif

endmodule

// File: rtl/tah_back.sv
// tah_back: applies bin operations to the bin store, tracks the largest
// total and holds the result register. Depends on tah_pkg and tah_ram.
`timescale 1ns / 1ps

module tah_back
  import tah_pkg::*;
#(
  parameter int BIN_COUNT = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  op_t       q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDX_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

  logic                 back_adv;
  logic                 b2_valid_r;
  op_t                  b2_op_r;
  logic [IDX_W-1:0]     b_addr;
  logic                 is_add, is_read, is_clear;
  logic [SEC_W-1:0]     rdata, cur_total, new_total;
  logic [SEC_W:0]       sum_wide;
  logic                 fwd_valid_r;
  logic [IDX_W-1:0]     fwd_addr_r;
  logic [SEC_W-1:0]     fwd_data_r;
  logic [BIN_COUNT-1:0] bin_valid_r;
  logic [SEC_W-1:0]     longest_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  assign b_addr   = b2_op_r.addr[IDX_W-1:0];
  assign is_add   = b2_valid_r && b2_op_r.kind == OP_ADD;
  assign is_clear = b2_valid_r && b2_op_r.kind == OP_CLEAR;
  assign is_read  = b2_valid_r && (b2_op_r.kind == OP_READ || b2_op_r.kind == OP_READ_OOB);
  assign back_adv = !(is_read && out_valid_r && out_stall);
  assign q_pop    = back_adv;

  // last write lands on the same edge as the next read, so bypass it
  assign cur_total = (fwd_valid_r && fwd_addr_r == b_addr) ? fwd_data_r :
                     (bin_valid_r[b_addr] ? rdata : '0);
  assign sum_wide  = {1'b0, cur_total} + {1'b0, b2_op_r.secs};
  assign new_total = sum_wide[SEC_W] ? '1 : sum_wide[SEC_W-1:0];

  tah_ram #(
    .WIDTH (SEC_W),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk   (clk),
    .we    (back_adv && is_add),
    .waddr (b_addr),
    .wdata (new_total),
    .re    (back_adv),
    .raddr (q_head.addr[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      bin_valid_r <= '0;
      longest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (back_adv && is_read) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (back_adv) begin
        b2_valid_r  <= !q_empty;
        fwd_valid_r <= is_add;
        if (is_add) begin
          bin_valid_r[b_addr] <= 1'b1;
          if (new_total > longest_r) begin
            longest_r <= new_total;
          end
        end
        if (is_clear) begin
          bin_valid_r <= '0;
          longest_r   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (back_adv) begin
      b2_op_r    <= q_head;
      fwd_addr_r <= b_addr;
      fwd_data_r <= new_total;
      if (is_read) begin
        out_data_r.bin_seconds     <= (b2_op_r.kind == OP_READ_OOB) ? '0 : cur_total;
        out_data_r.longest_seconds <= longest_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (back_adv && is_clear) |=> (longest_r == '0 && bin_valid_r == '0))
    else $error("clear left bin state behind");
`endif

endmodule
